FILE: src/mpbp_pkg.sv
// Shared types, constants and controller encodings for the Mandelbrot pixel bit packer.
package mpbp_pkg;

    localparam int ITERATIONS = 50;
    localparam int ITER_W     = $clog2(ITERATIONS + 1);

    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int STEP_W  = 30;
    localparam int Q_W     = 32;
    localparam int PROD_W  = 64;
    localparam int WIDE_W  = 44;
    localparam int CPROD_W = COORD_W + STEP_W;
    localparam int FRAC_BITS = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    localparam logic signed [WIDE_W-1:0] OFFSET_RE = WIDE_W'(402653184);
    localparam logic signed [WIDE_W-1:0] OFFSET_IM = WIDE_W'(268435456);
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(4) << 56;

    localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = SIZE_W'(256);
    localparam logic [STEP_W-1:0] STEP_SIZE_RESET  = STEP_W'(2097152);
    localparam logic [2:0]        BIT_POS_FIRST    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd1;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_end;
    } byte_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_ADD,
        ST_PACK
    } state_t;

    typedef struct packed {
        logic load_pixel;
        logic setup;
        logic mul;
        logic add;
        logic pack;
    } dp_cmd_t;

    typedef struct packed {
        logic escaped;
        logic iter_done;
        logic emit_needed;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: src/mpbp_ctrl.sv
// Sequencer for one pixel: setup, square/update iterations, then bit packing.
module mpbp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output mpbp_pkg::dp_cmd_t   cmd,
    input  mpbp_pkg::dp_status_t status
);

    mpbp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpbp_pkg::ST_IDLE: begin
                if (s_valid) state_next = mpbp_pkg::ST_SETUP;
            end
            mpbp_pkg::ST_SETUP: state_next = mpbp_pkg::ST_MUL;
            mpbp_pkg::ST_MUL:   state_next = mpbp_pkg::ST_ADD;
            mpbp_pkg::ST_ADD: begin
                if (status.escaped || status.iter_done) state_next = mpbp_pkg::ST_PACK;
                else state_next = mpbp_pkg::ST_MUL;
            end
            mpbp_pkg::ST_PACK: begin
                if (!(status.emit_needed && status.out_busy)) state_next = mpbp_pkg::ST_IDLE;
            end
            default: state_next = mpbp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            mpbp_pkg::ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_pixel = s_valid;
            end
            mpbp_pkg::ST_SETUP: cmd.setup = 1'b1;
            mpbp_pkg::ST_MUL:   cmd.mul   = 1'b1;
            mpbp_pkg::ST_ADD:   cmd.add   = 1'b1;
            mpbp_pkg::ST_PACK: begin
                // hold while a byte that is due would overwrite an untaken one
                cmd.pack = !(status.emit_needed && status.out_busy);
            end
            default: cmd = '0;
        endcase
    end

endmodule

FILE: src/mpbp_datapath.sv
// Fixed-point escape-time datapath, configuration registers and byte packer.
module mpbp_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mpbp_pkg::pixel_in_t                   s_data,
    input  mpbp_pkg::dp_cmd_t                     cmd,
    output mpbp_pkg::dp_status_t                  status,
    input  logic                                  cfg_valid,
    input  logic [mpbp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mpbp_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mpbp_pkg::byte_out_t                   m_data
);

    localparam int QW = mpbp_pkg::Q_W;
    localparam int PW = mpbp_pkg::PROD_W;
    localparam int WW = mpbp_pkg::WIDE_W;

    function automatic logic signed [QW-1:0] sat_q(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] hi;
        logic signed [WW-1:0] lo;
        hi = WW'({1'b0, {(QW-1){1'b1}}});
        lo = -hi - WW'(1);
        if (v > hi) return QW'(hi);
        if (v < lo) return QW'(lo);
        return QW'(v);
    endfunction

    // configuration
    logic [mpbp_pkg::SIZE_W-1:0] image_size_reg;
    logic [mpbp_pkg::STEP_W-1:0] step_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= mpbp_pkg::IMAGE_SIZE_RESET;
            step_size_reg  <= mpbp_pkg::STEP_SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                mpbp_pkg::CFG_IMAGE_SIZE: image_size_reg <= cfg_data[mpbp_pkg::SIZE_W-1:0];
                mpbp_pkg::CFG_STEP_SIZE:  step_size_reg  <= cfg_data[mpbp_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel capture and c setup
    logic [mpbp_pkg::COORD_W-1:0] x_reg, y_reg;
    logic signed [QW-1:0]         cr_reg, ci_reg;
    logic                         last_col_reg;

    logic [mpbp_pkg::CPROD_W-1:0] xprod, yprod;
    logic signed [WW-1:0]         cr_wide, ci_wide;
    logic                         last_col_next;

    always_comb begin
        xprod   = mpbp_pkg::CPROD_W'(x_reg) * mpbp_pkg::CPROD_W'(step_size_reg);
        yprod   = mpbp_pkg::CPROD_W'(y_reg) * mpbp_pkg::CPROD_W'(step_size_reg);
        cr_wide = $signed(WW'(xprod)) - mpbp_pkg::OFFSET_RE;
        ci_wide = $signed(WW'(yprod)) - mpbp_pkg::OFFSET_IM;
        // size zero wraps to all ones, which no column reaches
        last_col_next = (image_size_reg != '0) &&
                        ({1'b0, x_reg} == (image_size_reg - mpbp_pkg::SIZE_W'(1)));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            x_reg <= s_data.pixel_x;
            y_reg <= s_data.pixel_y;
        end
        if (cmd.setup) begin
            cr_reg       <= sat_q(cr_wide);
            ci_reg       <= sat_q(ci_wide);
            last_col_reg <= last_col_next;
        end
    end

    // iteration: products registered, then update and escape test
    logic signed [QW-1:0]     zr_reg, zi_reg;
    logic signed [PW-1:0]     rr_reg, ii_reg, ri_reg;
    logic [mpbp_pkg::ITER_W-1:0] iter_reg;
    logic                     inside_reg;

    logic signed [PW-1:0]     diff;
    logic signed [WW-1:0]     nr_wide, ni_wide;
    logic [PW-1:0]            mag;
    logic                     escaped, iter_done;

    always_comb begin
        diff      = rr_reg - ii_reg;
        nr_wide   = WW'(diff >>> mpbp_pkg::FRAC_BITS) + WW'(cr_reg);
        ni_wide   = WW'(ri_reg >>> (mpbp_pkg::FRAC_BITS - 1)) + WW'(ci_reg);
        mag       = $unsigned(rr_reg) + $unsigned(ii_reg);
        escaped   = mag > mpbp_pkg::ESCAPE_LIMIT;
        iter_done = iter_reg == mpbp_pkg::ITER_W'(mpbp_pkg::ITERATIONS);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rr_reg <= PW'(zr_reg) * PW'(zr_reg);
            ii_reg <= PW'(zi_reg) * PW'(zi_reg);
            ri_reg <= PW'(zr_reg) * PW'(zi_reg);
        end
        if (cmd.setup) begin
            zr_reg <= '0;
            zi_reg <= '0;
        end else if (cmd.add && !escaped && !iter_done) begin
            zr_reg <= sat_q(nr_wide);
            zi_reg <= sat_q(ni_wide);
        end
        if (cmd.add) inside_reg <= !escaped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= '0;
        end else if (cmd.setup) begin
            iter_reg <= '0;
        end else if (cmd.add && !escaped && !iter_done) begin
            iter_reg <= iter_reg + mpbp_pkg::ITER_W'(1);
        end
    end

    // bit packer and output register
    logic [2:0]          bit_pos_reg;
    logic [7:0]          partial_reg;
    logic                m_valid_reg;
    mpbp_pkg::byte_out_t m_data_reg;

    logic [7:0] byte_val;
    logic       emit;

    always_comb begin
        byte_val = partial_reg;
        byte_val[bit_pos_reg] = inside_reg;
        emit = (bit_pos_reg == 3'd0) || last_col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_pos_reg <= mpbp_pkg::BIT_POS_FIRST;
            partial_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.pack && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.pack) begin
                if (emit) begin
                    bit_pos_reg <= mpbp_pkg::BIT_POS_FIRST;
                    partial_reg <= '0;
                end else begin
                    bit_pos_reg <= bit_pos_reg - 3'd1;
                    partial_reg <= byte_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pack && emit) begin
            m_data_reg.packed_byte <= byte_val;
            m_data_reg.row_end     <= last_col_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.escaped     = escaped;
    assign status.iter_done   = iter_done;
    assign status.emit_needed = emit;
    assign status.out_busy    = m_valid_reg && !m_ready;

    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= mpbp_pkg::ITER_W'(mpbp_pkg::ITERATIONS))
        else $error("iteration count ran past its limit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pack && emit |-> !(m_valid_reg && !m_ready))
        else $error("byte emitted over an untaken result");

    a_restart_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pack && emit |=> bit_pos_reg == mpbp_pkg::BIT_POS_FIRST && partial_reg == '0)
        else $error("packer not restarted after emitting a byte");

endmodule

FILE: src/mandelbrot_pixel_bit_packer_unit.sv
// Top level of the Mandelbrot pixel classifier with MSB-first bit packing.
// Each accepted beat is one pixel; the block computes c from the pixel position and
// step_size, iterates z = z*z + c in Q4.28 until |z|^2 > 4 or ITERATIONS updates, and
// packs the resulting bit into a byte, emitting it when full or at column image_size-1.
// One pixel is in flight at a time: each iteration forms the three 32x32 products of
// z in the MUL state, then does the update and escape test in the ADD state. A finished
// byte waits in the output register while the next pixel is worked on; packing stalls
// only if a second byte is due before the first has been taken. Configuration beats
// are always taken.
module mandelbrot_pixel_bit_packer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  mpbp_pkg::pixel_in_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output mpbp_pkg::byte_out_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mpbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpbp_pkg::CFG_DATA_W-1:0] cfg_data
);

    mpbp_pkg::dp_cmd_t    cmd;
    mpbp_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mpbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    mpbp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: verif/mpbp_bitmap_checker.sv
// Checker for the pixel bit packer: rebuilds each packed bitmap byte and compares it.
module mpbp_bitmap_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  mpbp_pkg::pixel_in_t             s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  mpbp_pkg::byte_out_t             m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mpbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpbp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              bytes_pending,
    output int                              bytes_checked
);
    import mpbp_pkg::*;

    typedef longint unsigned u64_t;

    localparam longint Q_MAX = 64'sh7FFF_FFFF;
    localparam longint Q_MIN = -64'sh8000_0000;

    logic [SIZE_W-1:0] width_px;
    logic [STEP_W-1:0] pitch;
    logic [2:0]        next_bit;
    logic [7:0]        gathered;
    byte_out_t         due_bytes[$];

    function automatic longint clamp_q428(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    function automatic longint offset_coord(input logic [COORD_W-1:0] pos,
                                            input logic [STEP_W-1:0] pitch_in,
                                            input longint offset);
        return clamp_q428(longint'(pos) * longint'(pitch_in) - offset);
    endfunction

    // escape-time loop in Q4.28; >>> on signed longint rounds toward minus infinity
    function automatic bit point_in_set(input longint cr, input longint ci);
        longint zr;
        longint zi;
        longint nr;
        longint ni;
        u64_t   mag;
        zr = 0;
        zi = 0;
        for (int k = 0; k < ITERATIONS; k++) begin
            nr = clamp_q428(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
            ni = clamp_q428(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
            zr = nr;
            zi = ni;
            mag = u64_t'(zr * zr) + u64_t'(zi * zi);
            if (mag > ESCAPE_LIMIT)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        byte_out_t seen;
        byte_out_t want;
        bit        in_set;
        bit        last_col;
        if (!aresetn) begin
            width_px      = IMAGE_SIZE_RESET;
            pitch         = STEP_SIZE_RESET;
            next_bit      = BIT_POS_FIRST;
            gathered      = '0;
            mismatches    = 0;
            bytes_checked = 0;
            due_bytes.delete();
        end else begin
            // check output first: a pixel taken at this edge cannot have its byte out yet
            if (m_valid && m_ready) begin
                seen = m_data;
                if (due_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t: byte %02h row_end %0b with nothing expected",
                             $time, seen.packed_byte, seen.row_end);
                end else begin
                    want = due_bytes.pop_front();
                    bytes_checked++;
                    if (seen.packed_byte !== want.packed_byte) begin
                        mismatches++;
                        $display("%0t: packed_byte expected %02h actual %02h",
                                 $time, want.packed_byte, seen.packed_byte);
                    end
                    if (seen.row_end !== want.row_end) begin
                        mismatches++;
                        $display("%0t: row_end expected %0b actual %0b",
                                 $time, want.row_end, seen.row_end);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_SIZE: width_px = cfg_data[SIZE_W-1:0];
                    CFG_STEP_SIZE:  pitch    = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                in_set = point_in_set(offset_coord(s_data.pixel_x, pitch, longint'(OFFSET_RE)),
                                      offset_coord(s_data.pixel_y, pitch, longint'(OFFSET_IM)));
                last_col = (width_px != 0) && (s_data.pixel_x == width_px - 1'b1);
                gathered[next_bit] = in_set;
                if (next_bit == 0 || last_col) begin
                    want.packed_byte = gathered;
                    want.row_end     = last_col;
                    due_bytes = {due_bytes, want};
                    next_bit = BIT_POS_FIRST;
                    gathered = '0;
                end else begin
                    next_bit = next_bit - 1'b1;
                end
            end
        end
        bytes_pending = due_bytes.size();
    end

endmodule

FILE: verif/tb_mandelbrot_pixel_bit_packer_unit.sv
// Testbench top for the pixel bit packer: reset, register setup, pixel beats and verdict.
module tb_mandelbrot_pixel_bit_packer_unit;
    import mpbp_pkg::*;

    localparam int IDLE_PCT      = 14;
    localparam int DRAIN_CYCLES  = 2 * ITERATIONS + 10;
    localparam int TARGET_PIXELS = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic [STEP_W-1:0]    STEP_TWO     = STEP_W'(1) << (FRAC_BITS + 1);
    localparam logic [STEP_W-1:0]    STEP_FULL    = '1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pixel_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    byte_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit calm = 1'b0;
    int mismatches;
    int bytes_pending;
    int bytes_checked;
    int pixels_sent   = 0;
    int settings_used = 1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mandelbrot_pixel_bit_packer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mpbp_bitmap_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .bytes_pending (bytes_pending),
        .bytes_checked (bytes_checked)
    );

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // valid stays up after a beat; whoever stops sending lowers it
    task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{pixel_x: px, pixel_y: py};
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    task automatic scan_row(input int size_px, input int first_x, input logic [COORD_W-1:0] py);
        for (int x = first_x; x < size_px; x++)
            send_pixel(COORD_W'(x), py);
    endtask

    // wait for every byte, then give a pixel that emits nothing time to finish
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bytes_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_view(input logic [SIZE_W-1:0] size_px,
                                input logic [STEP_W-1:0] pitch, input bit spare);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        logic [CFG_DATA_W-1:0] size_word;
        int n;
        n = 0;
        size_word = CFG_DATA_W'(size_px);
        if ($urandom_range(1, 0))
            size_word[CFG_DATA_W-1:SIZE_W] = $urandom;
        if (spare) begin
            idx[n] = $urandom_range(1, 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
            val[n] = CFG_DATA_W'($urandom);
            n++;
        end
        if ($urandom_range(1, 0)) begin
            idx[n] = CFG_STEP_SIZE;  val[n] = pitch;
            idx[n+1] = CFG_IMAGE_SIZE; val[n+1] = size_word;
        end else begin
            idx[n] = CFG_IMAGE_SIZE; val[n] = size_word;
            idx[n+1] = CFG_STEP_SIZE;  val[n+1] = pitch;
        end
        n += 2;
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [SIZE_W-1:0] size_px;
        logic [STEP_W-1:0] pitch;
        int phase;
        int pick;
        int quota;
        int first_x;
        int goal;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset view: 1/128 per pixel, c = 0 at column 192 row 128
        send_pixel(0, 0);
        send_pixel(192, 128);
        send_pixel(4095, 4095);
        send_pixel(0, 128);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(100, 128);            // full byte mid-row
        send_pixel(160, 100);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(200, 128);
        send_pixel(255, 128);            // short byte closed by the last column
        for (int k = 0; k < 7; k++)
            send_pixel(COORD_W'(190 + k), COORD_W'(120 + k));
        send_pixel(255, 128);            // full byte landing on the last column
        drain();

        goal  = pixels_sent + TARGET_PIXELS;
        phase = 0;
        while (pixels_sent < goal) begin
            case (phase)
                0: begin size_px = 1;  pitch = STEP_TWO;       end
                1: begin size_px = 4096; pitch = STEP_TWO >> 12; end
                2: begin size_px = 0;  pitch = '0;             end
                3: begin size_px = '1; pitch = STEP_FULL;      end
                default: begin
                    pick    = $urandom_range(9, 0);
                    size_px = SIZE_W'($urandom_range(24, 1));
                    pitch   = STEP_TWO / size_px;
                    if (pick == 0)
                        pitch = STEP_W'($urandom);
                    else if (pick == 1)
                        pitch = pitch + STEP_W'($urandom_range(65535, 0)) - STEP_W'(32768);
                    else if (pick == 2)
                        size_px = SIZE_W'($urandom_range(8191, 25));
                end
            endcase
            calm = (phase >= 5 && phase <= 7);
            program_view(size_px, pitch, $urandom_range(3, 0) == 0);
            quota = $urandom_range(90, 40);
            while (quota > 0) begin
                if (size_px != 0 && size_px <= 32 && $urandom_range(9, 0) != 0) begin
                    first_x = ($urandom_range(3, 0) == 0) ? $urandom_range(size_px - 1, 0) : 0;
                    scan_row(size_px, first_x, COORD_W'($urandom_range(size_px - 1, 0)));
                    quota -= size_px - first_x;
                end else begin
                    if (size_px != 0 && $urandom_range(3, 0) == 0)
                        send_pixel(COORD_W'(size_px - 1'b1), COORD_W'($urandom));
                    else
                        send_pixel(COORD_W'($urandom), COORD_W'($urandom));
                    quota--;
                end
            end
            drain();
            phase++;
        end
        calm = 1'b0;

        $display("covered %0d pixels, %0d packed bytes checked, %0d register settings",
                 pixels_sent, bytes_checked, settings_used);
        $display("sizes 0 to 8191, steps zero to full scale, stalls on both channels");
        if (mismatches == 0)
            $display("tb_mandelbrot_pixel_bit_packer_unit OK");
        else
            $display("tb_mandelbrot_pixel_bit_packer_unit NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_mandelbrot_pixel_bit_packer_unit NOT OK");
        $finish;
    end

endmodule

FILE: files.f
src/mpbp_pkg.sv
src/mpbp_ctrl.sv
src/mpbp_datapath.sv
src/mandelbrot_pixel_bit_packer_unit.sv
verif/mpbp_bitmap_checker.sv
verif/tb_mandelbrot_pixel_bit_packer_unit.sv
